/* src/length_prefixed_nal_to_start_codes_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the NAL length-prefix to start-code converter
// Concurrent checks with a common clock, reset and report format.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_NAL_TO_START_CODES_MACROS_SVH
`define LENGTH_PREFIXED_NAL_TO_START_CODES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPN_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lpn_pkg.sv */
// ----------------------------------------------------------------------------
// lpn_pkg
// Types and constants shared by the converter's front end, queue and back end.
// ----------------------------------------------------------------------------
package lpn_pkg;

   localparam int SAMPLE_LENGTH_BITS = 24;
   localparam int OUT_POSITION_BITS  = 26;
   localparam int LFS_BITS           = 3;
   localparam int CSR_DATA_BITS      = OUT_POSITION_BITS;
   // Wide enough for position + 4 + a 32-bit unit length without wrapping.
   localparam int WIDE_BITS          = 34;

   localparam int CMD_DEPTH    = 4;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);

   localparam logic [LFS_BITS-1:0]          LFS_RESET = LFS_BITS'(4);
   localparam logic [OUT_POSITION_BITS-1:0] CAP_RESET = OUT_POSITION_BITS'(2097152);

   // Configuration register indexes.
   localparam logic CSR_IDX_LFS = 1'b0;
   localparam logic CSR_IDX_CAP = 1'b1;

   localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_PAYLOAD,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      CMD_BYTE,   // one payload byte
      CMD_START,  // four start-code bytes
      CMD_END,    // empty result that only closes the frame
      CMD_ABORT   // capacity exceeded
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                  kind;
      logic [7:0]                    data;
      logic                          last;
      logic [OUT_POSITION_BITS-1:0]  pos;
   } cmd_type;

   typedef struct packed {
      logic [LFS_BITS-1:0]           lfs;
      logic [OUT_POSITION_BITS-1:0]  cap;
   } cfg_type;

endpackage

/* src/length_prefixed_nal_to_start_codes.sv */
// ----------------------------------------------------------------------------
// length_prefixed_nal_to_start_codes
// Converts length-prefixed NAL units to start-code form, one byte at a time.
// ----------------------------------------------------------------------------
//  Channel   Handshake         Payload
//  request   push / full       req_data_byte, req_sample_first, req_sample_length
//  response  empty / pop       rsp_out_byte, rsp_byte_present, rsp_frame_end,
//                              rsp_overflow_error, rsp_total_out_length
//  csr       csr_valid / ready csr_index, csr_data
//
// One input byte is accepted per cycle while the four-entry command queue has room.
// A payload byte gives one result and a start code four; results leave one a cycle
// while they are popped, so the output register sets the rate when units are short.
// A result passes through the command queue and then the output register before it is visible.
// Synchronous reset leaves the parser idle, the command queue and output register empty.
// ----------------------------------------------------------------------------
`include "length_prefixed_nal_to_start_codes_macros.svh"

module length_prefixed_nal_to_start_codes
   import lpn_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_sample_first,
   input  logic [SAMPLE_LENGTH_BITS-1:0] req_sample_length,
   output logic                          empty,
   input  logic                          pop,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_byte_present,
   output logic                          rsp_frame_end,
   output logic                          rsp_overflow_error,
   output logic [OUT_POSITION_BITS-1:0]  rsp_total_out_length,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   logic    cmd_pop;
   logic    cmd_empty;
   cmd_type cmd_head;

   assign csr_ready = 1'b1;
   assign accept    = push && !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IDX_LFS: cfg_in.lfs = csr_data[LFS_BITS-1:0];
            CSR_IDX_CAP: cfg_in.cap = csr_data[OUT_POSITION_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lfs <= LFS_RESET;
         cfg_ff.cap <= CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpn_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_data_byte     (req_data_byte),
      .req_sample_first  (req_sample_first),
      .req_sample_length (req_sample_length),
      .cfg               (cfg_ff),
      .cmd_push          (cmd_push),
      .cmd               (cmd)
   );

   lpn_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (cmd_push),
      .push_cmd   (cmd),
      .pop_en     (cmd_pop),
      .fifo_full  (full),
      .fifo_empty (cmd_empty),
      .head       (cmd_head)
   );

   lpn_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_empty            (cmd_empty),
      .head                 (cmd_head),
      .cmd_pop              (cmd_pop),
      .pop                  (pop),
      .empty                (empty),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_byte_present     (rsp_byte_present),
      .rsp_frame_end        (rsp_frame_end),
      .rsp_overflow_error   (rsp_overflow_error),
      .rsp_total_out_length (rsp_total_out_length)
   );

   // An aborted frame is closed by its error result, which carries no byte.
   `LPN_ASSERT_IMPLY(a_err_ends_frame, clock, reset, !empty && rsp_overflow_error, rsp_frame_end && !rsp_byte_present, "overflow result must end the frame without a byte")
   // Only the closing result of a frame may lack a byte.
   `LPN_ASSERT_IMPLY(a_gap_ends_frame, clock, reset, !empty && !rsp_byte_present, rsp_frame_end, "empty result must carry frame end")
   // The input side can only fill up through an accepted byte.
   `LPN_ASSERT_NEXT(a_full_after_push, clock, reset, !full && !push, !full, "queue filled without a push")

endmodule

/* src/lpn_front.sv */
// ----------------------------------------------------------------------------
// lpn_front
// Parses length prefixes byte by byte and turns each accepted byte into at
// most one command for the back end.
// ----------------------------------------------------------------------------
module lpn_front
   import lpn_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_sample_first,
   input  logic [SAMPLE_LENGTH_BITS-1:0] req_sample_length,
   input  cfg_type                       cfg,
   output logic                          cmd_push,
   output cmd_type                       cmd
);

   phase_type                     phase_ff, phase_in;
   logic [1:0]                    hbs_ff, hbs_in;
   logic [23:0]                   acc_ff, acc_in;
   logic [SAMPLE_LENGTH_BITS-1:0] pl_ff, pl_in;
   logic [SAMPLE_LENGTH_BITS-1:0] sp_ff, sp_in;
   logic [OUT_POSITION_BITS-1:0]  op_ff, op_in;

   phase_type                     phase_cur;
   logic [1:0]                    hbs_cur;
   logic [23:0]                   acc_cur;
   logic [SAMPLE_LENGTH_BITS-1:0] pl_cur;
   logic [SAMPLE_LENGTH_BITS-1:0] sp_cur;
   logic [OUT_POSITION_BITS-1:0]  op_cur;

   logic [LFS_BITS-1:0]           nls;
   logic [31:0]                   unit;
   logic                          last;
   logic                          frag_short;
   logic                          unit_past_end;
   logic                          over_cap;
   logic                          abort;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hbs_ff   <= '0;
         acc_ff   <= '0;
         pl_ff    <= '0;
         sp_ff    <= '0;
         op_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         hbs_ff   <= hbs_in;
         acc_ff   <= acc_in;
         pl_ff    <= pl_in;
         sp_ff    <= sp_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      // A new sample clears the parser before the byte is looked at.
      if (req_sample_first) begin
         phase_cur = PH_HEADER;
         hbs_cur   = '0;
         acc_cur   = '0;
         pl_cur    = '0;
         sp_cur    = '0;
         op_cur    = '0;
      end else begin
         phase_cur = phase_ff;
         hbs_cur   = hbs_ff;
         acc_cur   = acc_ff;
         pl_cur    = pl_ff;
         sp_cur    = sp_ff;
         op_cur    = op_ff;
      end

      if (cfg.lfs == '0) begin
         nls = LFS_BITS'(1);
      end else if (cfg.lfs > LFS_BITS'(4)) begin
         nls = LFS_BITS'(4);
      end else begin
         nls = cfg.lfs;
      end

      unit          = {acc_cur, req_data_byte};
      last          = ({1'b0, sp_cur} + (SAMPLE_LENGTH_BITS+1)'(1))
                      >= {1'b0, req_sample_length};
      frag_short    = ({1'b0, sp_cur} + (SAMPLE_LENGTH_BITS+1)'(nls))
                      > {1'b0, req_sample_length};
      unit_past_end = (WIDE_BITS'(sp_cur) + WIDE_BITS'(1) + WIDE_BITS'(unit))
                      > WIDE_BITS'(req_sample_length);
      over_cap      = (WIDE_BITS'(op_cur) + WIDE_BITS'(4) + WIDE_BITS'(unit))
                      > WIDE_BITS'(cfg.cap);

      phase_in = phase_ff;
      hbs_in   = hbs_ff;
      acc_in   = acc_ff;
      pl_in    = pl_ff;
      sp_in    = sp_ff;
      op_in    = op_ff;
      cmd_push = 1'b0;
      abort    = 1'b0;
      cmd.kind = CMD_BYTE;
      cmd.data = req_data_byte;
      cmd.last = 1'b0;
      cmd.pos  = op_cur;

      if (accept) begin
         phase_in = phase_cur;
         hbs_in   = hbs_cur;
         acc_in   = acc_cur;
         pl_in    = pl_cur;
         sp_in    = sp_cur;
         op_in    = op_cur;

         unique case (phase_cur)
            PH_HEADER: begin
               if (hbs_cur == 2'd0 && frag_short) begin
                  phase_in = PH_SKIP;
               end else if ((LFS_BITS'(hbs_cur) + LFS_BITS'(1)) >= nls) begin
                  hbs_in = '0;
                  acc_in = '0;
                  if (unit_past_end) begin
                     phase_in = PH_SKIP;
                  end else if (over_cap) begin
                     cmd_push = 1'b1;
                     cmd.kind = CMD_ABORT;
                     phase_in = PH_IDLE;
                     abort    = 1'b1;
                  end else begin
                     cmd_push = 1'b1;
                     cmd.kind = CMD_START;
                     op_in    = op_cur + OUT_POSITION_BITS'(4);
                     pl_in    = unit[SAMPLE_LENGTH_BITS-1:0];
                     phase_in = (unit != '0) ? PH_PAYLOAD : PH_HEADER;
                  end
               end else begin
                  acc_in = unit[23:0];
                  hbs_in = hbs_cur + 2'd1;
               end
            end
            PH_PAYLOAD: begin
               cmd_push = 1'b1;
               cmd.kind = CMD_BYTE;
               op_in    = op_cur + OUT_POSITION_BITS'(1);
               cmd.pos  = op_cur + OUT_POSITION_BITS'(1);
               pl_in    = pl_cur - SAMPLE_LENGTH_BITS'(1);
               if (pl_cur == SAMPLE_LENGTH_BITS'(1)) begin
                  phase_in = PH_HEADER;
                  hbs_in   = '0;
                  acc_in   = '0;
               end
            end
            PH_SKIP: begin
            end
            PH_IDLE: begin
            end
         endcase

         if (phase_cur != PH_IDLE && !abort) begin
            sp_in = sp_cur + SAMPLE_LENGTH_BITS'(1);
            if (last) begin
               phase_in = PH_IDLE;
               cmd.last = 1'b1;
               if (!cmd_push) begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_END;
                  cmd.pos  = op_cur;
               end
            end
         end
      end
   end

endmodule

/* src/lpn_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// lpn_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lpn_cmd_fifo
   import lpn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_en,
   input  cmd_type push_cmd,
   input  logic    pop_en,
   output logic    fifo_full,
   output logic    fifo_empty,
   output cmd_type head
);

   cmd_type                 entries_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_BITS:0]   count_ff, count_in;

   assign fifo_full  = (count_ff == (CMD_PTR_BITS+1)'(CMD_DEPTH));
   assign fifo_empty = (count_ff == '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_en ? wr_ptr_ff + CMD_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop_en  ? rd_ptr_ff + CMD_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_en && !pop_en) begin
         count_in = count_ff + (CMD_PTR_BITS+1)'(1);
      end else if (pop_en && !push_en) begin
         count_in = count_ff - (CMD_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The entries are cleared so that the head is always a defined command.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CMD_DEPTH; i++) begin
            entries_ff[i] <= '0;
         end
      end else if (push_en) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/lpn_back.sv */
// ----------------------------------------------------------------------------
// lpn_back
// Expands queued commands into results and holds them in the output
// register until they are popped.
// ----------------------------------------------------------------------------
module lpn_back
   import lpn_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_empty,
   input  cmd_type                      head,
   output logic                         cmd_pop,
   input  logic                         pop,
   output logic                         empty,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_byte_present,
   output logic                         rsp_frame_end,
   output logic                         rsp_overflow_error,
   output logic [OUT_POSITION_BITS-1:0] rsp_total_out_length
);

   logic                         out_valid_ff, out_valid_in;
   logic [1:0]                   sc_idx_ff, sc_idx_in;
   logic [7:0]                   byte_ff, byte_in;
   logic                         present_ff, present_in;
   logic                         fe_ff, fe_in;
   logic                         err_ff, err_in;
   logic [OUT_POSITION_BITS-1:0] total_ff, total_in;
   logic                         load;
   logic                         take;
   logic                         done;

   assign empty                = !out_valid_ff;
   assign rsp_out_byte         = byte_ff;
   assign rsp_byte_present     = present_ff;
   assign rsp_frame_end        = fe_ff;
   assign rsp_overflow_error   = err_ff;
   assign rsp_total_out_length = total_ff;

   always_comb begin
      load = !out_valid_ff || pop;
      take = load && !cmd_empty;

      byte_in    = 8'h00;
      present_in = 1'b0;
      fe_in      = 1'b1;
      err_in     = 1'b0;
      total_in   = head.pos;
      done       = 1'b1;

      unique case (head.kind)
         CMD_BYTE: begin
            byte_in    = head.data;
            present_in = 1'b1;
            fe_in      = head.last;
         end
         CMD_START: begin
            // The start code leaves one byte a cycle while results are popped;
            // the command stays at the queue head until its fourth byte has gone.
            byte_in    = START_CODE[sc_idx_ff];
            present_in = 1'b1;
            done       = (sc_idx_ff == 2'd3);
            fe_in      = head.last && done;
            total_in   = head.pos + OUT_POSITION_BITS'(sc_idx_ff) + OUT_POSITION_BITS'(1);
         end
         CMD_END: begin
         end
         CMD_ABORT: begin
            err_in = 1'b1;
         end
      endcase

      cmd_pop      = take && done;
      sc_idx_in    = take ? (done ? 2'd0 : sc_idx_ff + 2'd1) : sc_idx_ff;
      out_valid_in = take ? 1'b1 : (load ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sc_idx_ff    <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         sc_idx_ff    <= sc_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff    <= byte_in;
         present_ff <= present_in;
         fe_ff      <= fe_in;
         err_ff     <= err_in;
         total_ff   <= total_in;
      end
   end

endmodule

/* tb/tb_length_prefixed_nal_to_start_codes.sv */
// ----------------------------------------------------------------------------
// tb_length_prefixed_nal_to_start_codes
// Streams length-prefixed samples into the converter, predicts the start-code
// output byte by byte and checks every response transaction in order.
// ----------------------------------------------------------------------------
module tb_length_prefixed_nal_to_start_codes;
   import lpn_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]                    data;
      logic                          first;
      logic [SAMPLE_LENGTH_BITS-1:0] slen;
   } sample_byte_type;

   typedef struct packed {
      logic [7:0]                   data;
      logic                         present;
      logic                         fe;
      logic                         err;
      logic [OUT_POSITION_BITS-1:0] total;
   } annexb_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          push = 1'b0;
   logic                          full;
   logic [7:0]                    req_data_byte = '0;
   logic                          req_sample_first = 1'b0;
   logic [SAMPLE_LENGTH_BITS-1:0] req_sample_length = '0;
   logic                          empty;
   logic                          pop = 1'b0;
   logic [7:0]                    rsp_out_byte;
   logic                          rsp_byte_present;
   logic                          rsp_frame_end;
   logic                          rsp_overflow_error;
   logic [OUT_POSITION_BITS-1:0]  rsp_total_out_length;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic                          csr_index = CSR_IDX_LFS;
   logic [CSR_DATA_BITS-1:0]      csr_data = '0;

   sample_byte_type   sample_bytes[$];
   annexb_result_type annexb_due[$];
   logic [7:0]        unit_bytes[$];
   bit                no_gaps = 1'b0;
   int                n_fail = 0;
   int                queued = 0;

   // Shadow configuration and converter state.
   logic [LFS_BITS-1:0]           cfg_prefix_bytes = LFS_RESET;
   logic [OUT_POSITION_BITS-1:0]  cfg_capacity = CAP_RESET;
   phase_type                     conv_phase = PH_IDLE;
   logic [1:0]                    prefix_seen = '0;
   logic [31:0]                   unit_acc = '0;
   logic [31:0]                   unit_left = '0;
   logic [SAMPLE_LENGTH_BITS-1:0] sample_pos = '0;
   logic [OUT_POSITION_BITS-1:0]  out_pos = '0;

   length_prefixed_nal_to_start_codes dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_data_byte        (req_data_byte),
      .req_sample_first     (req_sample_first),
      .req_sample_length    (req_sample_length),
      .empty                (empty),
      .pop                  (pop),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_byte_present     (rsp_byte_present),
      .rsp_frame_end        (rsp_frame_end),
      .rsp_overflow_error   (rsp_overflow_error),
      .rsp_total_out_length (rsp_total_out_length),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("Verification failed");
      $finish;
   end

   function automatic int prefix_size(input logic [LFS_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > 4) return 4;
      return v;
   endfunction

   function automatic annexb_result_type result_of(input logic [7:0] d, input logic pr,
                                                   input logic fe, input logic er,
                                                   input logic [OUT_POSITION_BITS-1:0] t);
      annexb_result_type r;
      r.data = d;
      r.present = pr;
      r.fe = fe;
      r.err = er;
      r.total = t;
      return r;
   endfunction

   // Advances the shadow converter by one accepted byte and queues what it owes.
   function automatic void convert_byte(input logic [7:0] b, input logic first,
                                        input logic [SAMPLE_LENGTH_BITS-1:0] slen);
      annexb_result_type step_out[4];
      int                n;
      int                nls;
      logic [63:0]       p;
      logic [63:0]       unit;
      logic              last;
      n = 0;
      nls = prefix_size(cfg_prefix_bytes);
      if (first) begin
         conv_phase = PH_HEADER;
         prefix_seen = '0;
         unit_acc = '0;
         unit_left = '0;
         sample_pos = '0;
         out_pos = '0;
      end
      if (conv_phase == PH_IDLE) return;
      p = sample_pos;
      last = (p + 1 >= slen);
      if (conv_phase == PH_HEADER) begin
         if (prefix_seen == 0 && p + nls > slen) begin
            conv_phase = PH_SKIP;
         end else begin
            unit_acc = {unit_acc[23:0], b};
            if (prefix_seen + 1 >= nls) begin
               unit = unit_acc;
               prefix_seen = '0;
               unit_acc = '0;
               if (p + 1 + unit > slen) begin
                  conv_phase = PH_SKIP;
               end else if (out_pos + 4 + unit > cfg_capacity) begin
                  // Aborted frame: one flagged result, then the rest is ignored.
                  annexb_due.push_back(result_of(8'h00, 1'b0, 1'b1, 1'b1, out_pos));
                  conv_phase = PH_IDLE;
                  return;
               end else begin
                  for (int i = 0; i < 4; i++) begin
                     out_pos = out_pos + 1'b1;
                     step_out[n] = result_of((i == 3) ? 8'h01 : 8'h00, 1'b1, 1'b0, 1'b0,
                                             out_pos);
                     n++;
                  end
                  unit_left = unit[31:0];
                  conv_phase = (unit != 0) ? PH_PAYLOAD : PH_HEADER;
               end
            end else begin
               prefix_seen = prefix_seen + 1'b1;
            end
         end
      end else if (conv_phase == PH_PAYLOAD) begin
         out_pos = out_pos + 1'b1;
         step_out[n] = result_of(b, 1'b1, 1'b0, 1'b0, out_pos);
         n++;
         unit_left = unit_left - 1;
         if (unit_left == 0) begin
            conv_phase = PH_HEADER;
            prefix_seen = '0;
            unit_acc = '0;
         end
      end
      sample_pos = SAMPLE_LENGTH_BITS'(p + 1);
      if (last) begin
         if (n > 0) begin
            step_out[n-1].fe = 1'b1;
         end else begin
            step_out[0] = result_of(8'h00, 1'b0, 1'b1, 1'b0, out_pos);
            n = 1;
         end
         conv_phase = PH_IDLE;
      end
      for (int i = 0; i < n; i++) annexb_due.push_back(step_out[i]);
   endfunction

   // Request side: holds a transaction until it is taken, with occasional gaps.
   always @(posedge clock) begin : drive_requests
      sample_byte_type nxt;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            convert_byte(req_data_byte, req_sample_first, req_sample_length);
         end
         if (!push || !full) begin
            if (sample_bytes.size() > 0 && (no_gaps || $urandom_range(99) >= 6)) begin
               nxt = sample_bytes.pop_front();
               push <= 1'b1;
               req_data_byte <= nxt.data;
               req_sample_first <= nxt.first;
               req_sample_length <= nxt.slen;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Response side: checks each popped transaction against the oldest prediction.
   always @(posedge clock) begin : check_responses
      annexb_result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (annexb_due.size() == 0) begin
               if (n_fail < 10)
                  $display("unexpected result: byte %02h present %0d end %0d err %0d total %0d",
                           rsp_out_byte, rsp_byte_present, rsp_frame_end,
                           rsp_overflow_error, rsp_total_out_length);
               n_fail++;
            end else begin
               want = annexb_due.pop_front();
               if (rsp_out_byte !== want.data || rsp_byte_present !== want.present ||
                   rsp_frame_end !== want.fe || rsp_overflow_error !== want.err ||
                   rsp_total_out_length !== want.total) begin
                  if (n_fail < 10)
                     $display("mismatch: expected %02h/%0d/%0d/%0d/%0d, got %02h/%0d/%0d/%0d/%0d",
                              want.data, want.present, want.fe, want.err, want.total,
                              rsp_out_byte, rsp_byte_present, rsp_frame_end,
                              rsp_overflow_error, rsp_total_out_length);
                  n_fail++;
               end
            end
         end
         pop <= no_gaps || $urandom_range(99) >= 6;
      end
   end

   task automatic queue_byte(input logic [7:0] d, input logic first,
                             input logic [SAMPLE_LENGTH_BITS-1:0] slen);
      sample_byte_type s;
      s.data = d;
      s.first = first;
      s.slen = slen;
      sample_bytes.push_back(s);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_IDX_LFS)
         cfg_prefix_bytes = val[LFS_BITS-1:0];
      else
         cfg_capacity = val;
   endtask

   // Header bytes give no result, so allow the pipeline to settle after the last one.
   task automatic drain();
      while (sample_bytes.size() > 0 || push || annexb_due.size() > 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic put_unit(input logic [31:0] len, input int nls, input int body);
      for (int k = nls - 1; k >= 0; k--) unit_bytes.push_back(8'(len >> (8 * k)));
      repeat (body) unit_bytes.push_back(8'($urandom));
   endtask

   // Mostly well-formed samples with random content; the rest are broken on purpose.
   task automatic make_sample();
      logic [31:0]                   ulen;
      logic [SAMPLE_LENGTH_BITS-1:0] slen;
      int                            nls;
      int                            kind;
      int                            cut;
      nls = prefix_size(cfg_prefix_bytes);
      kind = $urandom_range(0, 9);
      cut = 0;
      repeat ($urandom_range(1, 4)) begin
         ulen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
         put_unit(ulen, nls, ulen);
      end
      if (kind == 7) begin
         repeat ($urandom_range(1, nls)) unit_bytes.push_back(8'($urandom));
      end else if (kind == 8) begin
         ulen = (nls == 4 && $urandom_range(0, 1)) ? $urandom : $urandom_range(2, 60);
         put_unit(ulen, nls, $urandom_range(0, 1));
      end
      slen = SAMPLE_LENGTH_BITS'(unit_bytes.size());
      if (kind == 9) begin
         case ($urandom_range(0, 4))
            0: slen = '0;
            1: slen = SAMPLE_LENGTH_BITS'($urandom_range(0, 24'hFFFFFF));
            2: slen = 24'hFFFFFF;
            3: if (unit_bytes.size() > 3)
                  slen = SAMPLE_LENGTH_BITS'(unit_bytes.size() - $urandom_range(1, 3));
            default: if (unit_bytes.size() > 1) cut = $urandom_range(1, unit_bytes.size() - 1);
         endcase
      end
      foreach (unit_bytes[i]) queue_byte(unit_bytes[i], i == 0 || i == cut && cut > 0, slen);
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 2))
            queue_byte(8'($urandom), 1'b0,
                       SAMPLE_LENGTH_BITS'($urandom_range(0, 24'hFFFFFF)));
      queued += unit_bytes.size();
      unit_bytes.delete();
   endtask

   initial begin
      logic [7:0] seq_a[10];
      seq_a = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration: four-byte prefixes, large capacity.
      queue_byte(8'hFF, 1'b0, 24'd5);
      foreach (seq_a[i]) queue_byte(seq_a[i], i == 0, 24'd10);
      // A unit that runs past the end of its sample.
      queue_byte(8'h00, 1'b1, 24'd6);
      queue_byte(8'h00, 1'b0, 24'd6);
      queue_byte(8'h00, 1'b0, 24'd6);
      queue_byte(8'h09, 1'b0, 24'd6);
      queue_byte(8'h12, 1'b0, 24'd6);
      queue_byte(8'h34, 1'b0, 24'd6);
      queue_byte(8'h80, 1'b1, 24'd0);
      // A huge sample cut short by a new one that is too short for a prefix.
      queue_byte(8'hFF, 1'b1, 24'hFFFFFF);
      queue_byte(8'hFF, 1'b0, 24'hFFFFFF);
      queue_byte(8'h00, 1'b1, 24'd1);
      drain();

      // Prefix size zero behaves as one; no capacity at all.
      write_reg(CSR_IDX_LFS, CSR_DATA_BITS'(0));
      write_reg(CSR_IDX_CAP, CSR_DATA_BITS'(0));
      queue_byte(8'h00, 1'b1, 24'd2);
      queue_byte(8'h7F, 1'b0, 24'd2);
      drain();

      // Prefix size seven behaves as four; largest capacity.
      write_reg(CSR_IDX_LFS, CSR_DATA_BITS'(7));
      write_reg(CSR_IDX_CAP, 26'h3FFFFFF);
      queue_byte(8'h01, 1'b1, 24'd3);
      queue_byte(8'h02, 1'b0, 24'd3);
      queue_byte(8'h03, 1'b0, 24'd3);
      drain();

      for (int r = 0; r < 6; r++) begin
         case (r)
            0: write_reg(CSR_IDX_LFS, CSR_DATA_BITS'(1));
            1: write_reg(CSR_IDX_LFS, CSR_DATA_BITS'(2));
            2: write_reg(CSR_IDX_LFS, CSR_DATA_BITS'(3));
            5: write_reg(CSR_IDX_LFS, CSR_DATA_BITS'($urandom_range(0, 7)));
            default: write_reg(CSR_IDX_LFS, CSR_DATA_BITS'(4));
         endcase
         if (r == 1)
            write_reg(CSR_IDX_CAP, CSR_DATA_BITS'($urandom_range(0, 40)));
         else if (r == 3)
            write_reg(CSR_IDX_CAP, CSR_DATA_BITS'($urandom_range(20, 150)));
         else
            write_reg(CSR_IDX_CAP, CSR_DATA_BITS'($urandom_range(200, 26'h3FFFFFF)));
         @(negedge clock);
         no_gaps = (r == 2);
         queued = 0;
         while (queued < 40) make_sample();
         drain();
      end

      if (n_fail == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* length_prefixed_nal_to_start_codes.f */
+incdir+src
src/lpn_pkg.sv
src/lpn_front.sv
src/lpn_cmd_fifo.sv
src/lpn_back.sv
src/length_prefixed_nal_to_start_codes.sv
tb/tb_length_prefixed_nal_to_start_codes.sv
